>>> rtl/bfic_pkg.sv
package bfic_pkg;

    // Default widths of the internal level and idle timer.
    localparam int LEVEL_WIDTH_DEF      = 8;
    localparam int IDLE_TIMER_WIDTH_DEF = 20;

    // Fixed widths of the configuration registers and result fields.
    localparam int BRIGHT_W   = 8;
    localparam int STEP_W     = 8;
    localparam int INTERVAL_W = 16;
    localparam int TIMEOUT_W  = 20;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [1:0] REG_MAX_BRIGHTNESS  = 2'd0;
    localparam logic [1:0] REG_STEP_SIZE       = 2'd1;
    localparam logic [1:0] REG_STEP_PERIOD     = 2'd2;
    localparam logic [1:0] REG_IDLE_TIMEOUT_MS = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [BRIGHT_W-1:0]   MAX_BRIGHTNESS_RST  = 8'd20;
    localparam logic [STEP_W-1:0]     STEP_SIZE_RST       = 8'd2;
    localparam logic [INTERVAL_W-1:0] STEP_PERIOD_RST     = 16'd60;
    localparam logic [TIMEOUT_W-1:0]  IDLE_TIMEOUT_MS_RST = 20'd30000;

    // Event kinds.
    localparam logic [1:0] FUNC_TICK       = 2'd0;
    localparam logic [1:0] FUNC_KEY        = 2'd1;
    localparam logic [1:0] FUNC_ACTIVITY   = 2'd2;
    localparam logic [1:0] FUNC_SET_ENABLE = 2'd3;

    // Light state codes as seen on the result word.
    localparam logic [1:0] LIGHT_CODE_OFF  = 2'd0;
    localparam logic [1:0] LIGHT_CODE_UP   = 2'd1;
    localparam logic [1:0] LIGHT_CODE_ON   = 2'd2;
    localparam logic [1:0] LIGHT_CODE_DOWN = 2'd3;

    typedef enum logic [3:0] {
        LS_OFF  = 4'b0001,
        LS_UP   = 4'b0010,
        LS_ON   = 4'b0100,
        LS_DOWN = 4'b1000
    } light_t;

    typedef struct packed {
        logic [1:0] func;
        logic       key_pressed;
        logic       key_is_local;
        logic       enable_value;
    } evt_word_t;

    typedef struct packed {
        logic [BRIGHT_W-1:0] brightness;
        logic [1:0]          light_state;
        logic                enabled;
    } res_word_t;

    typedef struct packed {
        logic [BRIGHT_W-1:0]   max_brightness;
        logic [STEP_W-1:0]     step_size;
        logic [INTERVAL_W-1:0] step_period;
        logic [TIMEOUT_W-1:0]  idle_timeout_ms;
    } cfg_t;

    function automatic logic [1:0] light_code(input light_t st);
        logic [1:0] code;
        case (st)
            LS_OFF:  code = LIGHT_CODE_OFF;
            LS_UP:   code = LIGHT_CODE_UP;
            LS_ON:   code = LIGHT_CODE_ON;
            LS_DOWN: code = LIGHT_CODE_DOWN;
            default: code = LIGHT_CODE_OFF;
        endcase
        return code;
    endfunction

endpackage

>>> rtl/bfic_engine.sv
module bfic_engine
    import bfic_pkg::*;
#(
    parameter int LEVEL_WIDTH      = LEVEL_WIDTH_DEF,
    parameter int IDLE_TIMER_WIDTH = IDLE_TIMER_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  evt_word_t evt,
    input  cfg_t      cfg,
    output res_word_t res
);

    // Arithmetic width: wide enough for level and for the 8-bit step and max.
    localparam int AW = ((LEVEL_WIDTH > BRIGHT_W) ? LEVEL_WIDTH : BRIGHT_W) + 1;

    light_t                      fsm_reg, fsm_next;
    logic [LEVEL_WIDTH-1:0]      level_reg, level_next;
    logic                        en_reg, en_next;
    logic [INTERVAL_W-1:0]       fade_reg, fade_next;
    logic [IDLE_TIMER_WIDTH-1:0] idle_reg, idle_next;
    logic                        armed_reg, armed_next;

    logic [AW-1:0]         lvl_ext, step_ext, max_ext;
    logic [AW-1:0]         up_sum, up_level, dn_diff, dn_level;
    logic                  up_hit, dn_hit;
    logic [INTERVAL_W-1:0] fade_reload;
    logic                  act;

    assign lvl_ext  = AW'(level_reg);
    assign step_ext = AW'(cfg.step_size);
    assign max_ext  = AW'(cfg.max_brightness);

    assign up_sum   = lvl_ext + step_ext;
    assign up_hit   = (up_sum >= max_ext);
    assign up_level = up_hit ? max_ext : up_sum;

    assign dn_hit   = (lvl_ext <= step_ext);
    assign dn_diff  = lvl_ext - step_ext;
    assign dn_level = dn_hit ? '0 : ((dn_diff > max_ext) ? max_ext : dn_diff);

    assign fade_reload = (cfg.step_period == '0) ? INTERVAL_W'(1) : cfg.step_period;

    always_comb
    begin
        fsm_next   = fsm_reg;
        level_next = level_reg;
        en_next    = en_reg;
        fade_next  = fade_reg;
        idle_next  = idle_reg;
        armed_next = armed_reg;
        act        = 1'b0;

        case (evt.func)
            FUNC_TICK:
            begin
                // The fade timer is served first; the idle check sees its outcome.
                if (fade_reg != '0)
                begin
                    fade_next = fade_reg - INTERVAL_W'(1);
                    if (fade_next == '0)
                    begin
                        if (!en_reg)
                        begin
                            fsm_next   = LS_OFF;
                            level_next = '0;
                        end
                        else if (fsm_reg == LS_UP)
                        begin
                            level_next = LEVEL_WIDTH'(up_level);
                            if (up_hit)
                            begin
                                fsm_next = LS_ON;
                            end
                            fade_next = fade_reload;
                        end
                        else if (fsm_reg == LS_DOWN)
                        begin
                            level_next = LEVEL_WIDTH'(dn_level);
                            if (dn_hit)
                            begin
                                fsm_next = LS_OFF;
                            end
                            fade_next = fade_reload;
                        end
                    end
                end
                if (armed_reg)
                begin
                    if (idle_reg <= IDLE_TIMER_WIDTH'(1))
                    begin
                        idle_next  = '0;
                        armed_next = 1'b0;
                        if (fsm_next == LS_ON)
                        begin
                            fsm_next = LS_DOWN;
                            if (fade_next == '0)
                            begin
                                fade_next = INTERVAL_W'(1);
                            end
                        end
                    end
                    else
                    begin
                        idle_next = idle_reg - IDLE_TIMER_WIDTH'(1);
                    end
                end
            end
            FUNC_KEY:
            begin
                act = evt.key_pressed && evt.key_is_local;
            end
            FUNC_ACTIVITY:
            begin
                act = 1'b1;
            end
            FUNC_SET_ENABLE:
            begin
                en_next = evt.enable_value;
                if (!evt.enable_value)
                begin
                    armed_next = 1'b0;
                    idle_next  = '0;
                    fade_next  = '0;
                    fsm_next   = LS_OFF;
                    level_next = '0;
                end
                else
                begin
                    act = 1'b1;
                end
            end
            default:
            begin
                act = 1'b0;
            end
        endcase

        // Activity only counts while enabled; it starts a fade up from off or fading down and rearms idle.
        if (act && en_next)
        begin
            if (fsm_next inside {LS_OFF, LS_DOWN})
            begin
                fsm_next = LS_UP;
                if (fade_next == '0)
                begin
                    fade_next = INTERVAL_W'(1);
                end
            end
            idle_next  = IDLE_TIMER_WIDTH'(cfg.idle_timeout_ms);
            armed_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg   <= LS_OFF;
            level_reg <= '0;
            en_reg    <= 1'b0;
            fade_reg  <= '0;
            idle_reg  <= '0;
            armed_reg <= 1'b0;
        end
        else if (fire)
        begin
            fsm_reg   <= fsm_next;
            level_reg <= level_next;
            en_reg    <= en_next;
            fade_reg  <= fade_next;
            idle_reg  <= idle_next;
            armed_reg <= armed_next;
        end
    end

    assign res.brightness  = BRIGHT_W'(level_next);
    assign res.light_state = light_code(fsm_next);
    assign res.enabled     = en_next;

endmodule

>>> rtl/backlight_fade_idle_controller_core.sv
// Path: an accepted word waits in the stage register, and its result is then
// registered in the result register; a stalled receiver can hold it in between.
// Throughput: one event word per cycle while the receiver does not stall; a result
// held by a stalled receiver fills the stage register and then raises evt_stall.
// Reset: rst_n is asynchronous and active low; it empties both pipeline registers,
// sets the light off at level 0, disabled, with both timers idle, and restores the
// configuration registers to their default values.
module backlight_fade_idle_controller_core
    import bfic_pkg::*;
#(
    parameter int LEVEL_WIDTH      = LEVEL_WIDTH_DEF,
    parameter int IDLE_TIMER_WIDTH = IDLE_TIMER_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Event channel.
    input  logic        evt_valid,
    output logic        evt_stall,
    input  evt_word_t   evt,
    // Result channel.
    output logic        res_valid,
    input  logic        res_stall,
    output res_word_t   res,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // The pipeline has two registers. The stage register holds an accepted event
    // word; the engine applies it to the controller state in the cycle it moves on,
    // and the result register then presents the state after the update. The stage
    // advances whenever the result register is empty or is being emptied; a result
    // waiting on a stalled receiver leaves one word in the stage register and then
    // stops the next word through evt_stall.

    logic      stage_valid_reg, stage_valid_next;
    evt_word_t stage_word_reg;
    logic      res_valid_reg, res_valid_next;
    res_word_t res_word_reg;
    res_word_t engine_res;
    cfg_t      cfg_reg;
    logic      advance;
    logic      evt_take;
    logic      cfg_write;

    assign advance   = stage_valid_reg && (!res_valid_reg || !res_stall);
    assign evt_stall = stage_valid_reg && !advance;
    assign evt_take  = evt_valid && !evt_stall;

    assign stage_valid_next = evt_take || (stage_valid_reg && !advance);
    assign res_valid_next   = advance || (res_valid_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    // Payload registers carry no reset; their valid bits guard them.
    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            stage_word_reg <= evt;
        end
        if (advance)
        begin
            res_word_reg <= engine_res;
        end
    end

    // The engine owns the light state machine, the level and both timers.
    bfic_engine #(
        .LEVEL_WIDTH      (LEVEL_WIDTH),
        .IDLE_TIMER_WIDTH (IDLE_TIMER_WIDTH)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .evt   (stage_word_reg),
        .cfg   (cfg_reg),
        .res   (engine_res)
    );

    assign res_valid = res_valid_reg;
    assign res       = res_word_reg;

    // Configuration registers. Writes complete in the access phase; pready is tied
    // high so every transfer finishes without wait states. Registers are decoded
    // by word address, and written values are cut to the register's width.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_brightness  <= MAX_BRIGHTNESS_RST;
            cfg_reg.step_size       <= STEP_SIZE_RST;
            cfg_reg.step_period     <= STEP_PERIOD_RST;
            cfg_reg.idle_timeout_ms <= IDLE_TIMEOUT_MS_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_MAX_BRIGHTNESS:  cfg_reg.max_brightness  <= pwdata[BRIGHT_W-1:0];
                REG_STEP_SIZE:       cfg_reg.step_size       <= pwdata[STEP_W-1:0];
                REG_STEP_PERIOD:     cfg_reg.step_period     <= pwdata[INTERVAL_W-1:0];
                REG_IDLE_TIMEOUT_MS: cfg_reg.idle_timeout_ms <= pwdata[TIMEOUT_W-1:0];
                default:             cfg_reg.max_brightness  <= cfg_reg.max_brightness;
            endcase
        end
    end

    // Read data returns the register at the addressed word, zero extended.
    always_comb
    begin
        case (paddr[3:2])
            REG_MAX_BRIGHTNESS:  prdata = 32'(cfg_reg.max_brightness);
            REG_STEP_SIZE:       prdata = 32'(cfg_reg.step_size);
            REG_STEP_PERIOD:     prdata = 32'(cfg_reg.step_period);
            REG_IDLE_TIMEOUT_MS: prdata = 32'(cfg_reg.idle_timeout_ms);
            default:             prdata = '0;
        endcase
    end

endmodule

>>> rtl/bfic_checker.sv
module bfic_checker
    import bfic_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      evt_stall,
    input res_word_t res,
    input logic      res_valid,
    input logic      res_stall
);

    // A result word held back by the receiver stays offered and unchanged.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result word changed while stalled");

    // The event side only stalls when a result is waiting on a stalled receiver.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        evt_stall |-> res_valid && res_stall)
        else $error("event stall without a blocked result");

    // A disabled backlight is always reported off.
    a_disabled_off: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.enabled |-> res.light_state == LIGHT_CODE_OFF)
        else $error("disabled backlight not off");

    // The off state is only ever entered at level zero.
    a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.light_state == LIGHT_CODE_OFF |-> res.brightness == '0)
        else $error("light off with nonzero brightness");

endmodule

bind backlight_fade_idle_controller_core bfic_checker u_bfic_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_stall (evt_stall),
    .res       (res),
    .res_valid (res_valid),
    .res_stall (res_stall)
);

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import bfic_pkg::*;

    // Clock, reset and the ports of the block.
    logic        clk = 1'b0;
    logic        rst_n;
    logic        evt_valid;
    logic        evt_stall;
    evt_word_t   evt;
    logic        res_valid;
    logic        res_stall;
    res_word_t   res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the configuration registers, updated on every register write.
    logic [BRIGHT_W-1:0]   cfg_max;
    logic [STEP_W-1:0]     cfg_step;
    logic [INTERVAL_W-1:0] cfg_interval;
    logic [TIMEOUT_W-1:0]  cfg_timeout;

    // Shadow copy of the backlight state, advanced once per accepted event word.
    logic [1:0]                      lamp_state;
    logic [LEVEL_WIDTH_DEF-1:0]      lamp_level;
    logic                            lamp_enabled;
    logic [INTERVAL_W-1:0]           fade_left;
    logic [IDLE_TIMER_WIDTH_DEF-1:0] idle_left;
    logic                            idle_live;

    // Result words that the block still owes us, oldest first.
    res_word_t due_res_q[$];
    int        mismatch_cnt = 0;

    // Pacing controls shared by the sender and the receiver.
    bit pace_on  = 1'b1;
    bit hold_req = 1'b0;
    int hold_len = 0;

    backlight_fade_idle_controller_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Backlight predictor.
    // ------------------------------------------------------------------

    // Arming the fade timer only takes effect when it is idle; a running
    // countdown keeps its current count.
    task automatic arm_fade();
        if (fade_left == 0)
        begin
            fade_left = INTERVAL_W'(1);
        end
    endtask

    // One fade step, run when the fade countdown reaches zero. The step that
    // ends a fade still rearms the timer, so one more expiry follows that
    // does nothing because the light is then steady on or off.
    task automatic step_fade();
        int v;
        int top;
        int stp;
        v   = int'(lamp_level);
        top = int'(cfg_max);
        stp = int'(cfg_step);
        if (!lamp_enabled)
        begin
            lamp_state = LIGHT_CODE_OFF;
            lamp_level = '0;
        end
        else if (lamp_state == LIGHT_CODE_UP || lamp_state == LIGHT_CODE_DOWN)
        begin
            if (lamp_state == LIGHT_CODE_UP)
            begin
                v = v + stp;
                if (v >= top)
                begin
                    v          = top;
                    lamp_state = LIGHT_CODE_ON;
                end
            end
            else
            begin
                v = v - stp;
                if (v <= 0)
                begin
                    v          = 0;
                    lamp_state = LIGHT_CODE_OFF;
                end
            end
            // A maximum lowered below the current level pulls the level down
            // at this step, whichever way the fade runs.
            if (v > top)
            begin
                v = top;
            end
            if (v < 0)
            begin
                v = 0;
            end
            lamp_level = v[LEVEL_WIDTH_DEF-1:0];
            fade_left  = (cfg_interval == 0) ? INTERVAL_W'(1) : cfg_interval;
        end
    endtask

    // Activity wakes the light from off or fading down and rearms the
    // single-shot idle timer, but only while the backlight is enabled.
    task automatic note_activity();
        if (lamp_enabled)
        begin
            if (lamp_state == LIGHT_CODE_OFF || lamp_state == LIGHT_CODE_DOWN)
            begin
                lamp_state = LIGHT_CODE_UP;
                arm_fade();
            end
            idle_left = cfg_timeout;
            idle_live = 1'b1;
        end
    endtask

    // A millisecond tick serves the fade timer first, then the idle timer.
    // An idle timeout of zero expires on the first tick, the same as one.
    task automatic run_tick();
        if (fade_left != 0)
        begin
            fade_left = fade_left - 1'b1;
            if (fade_left == 0)
            begin
                step_fade();
            end
        end
        if (idle_live)
        begin
            if (idle_left <= 1)
            begin
                idle_left = '0;
                idle_live = 1'b0;
                if (lamp_state == LIGHT_CODE_ON)
                begin
                    lamp_state = LIGHT_CODE_DOWN;
                    arm_fade();
                end
            end
            else
            begin
                idle_left = idle_left - 1'b1;
            end
        end
    endtask

    // Apply one event word and return the result word it must produce.
    task automatic advance_backlight(input evt_word_t w, output res_word_t r);
        case (w.func)
            FUNC_TICK:
            begin
                run_tick();
            end
            FUNC_KEY:
            begin
                // Releases and keys from the remote half are ignored.
                if (w.key_pressed && w.key_is_local)
                begin
                    note_activity();
                end
            end
            FUNC_ACTIVITY:
            begin
                note_activity();
            end
            default:
            begin
                lamp_enabled = w.enable_value;
                if (!w.enable_value)
                begin
                    // Disable cancels both timers and forces the light dark.
                    idle_live  = 1'b0;
                    idle_left  = '0;
                    fade_left  = '0;
                    lamp_state = LIGHT_CODE_OFF;
                    lamp_level = '0;
                end
                else
                begin
                    note_activity();
                end
            end
        endcase
        r.brightness  = lamp_level;
        r.light_state = lamp_state;
        r.enabled     = lamp_enabled;
    endtask

    // ------------------------------------------------------------------
    // Monitor: predicts on every accepted event word and checks every
    // accepted result word against the oldest outstanding prediction.
    // Sampling at the clock edge sees the values from before the edge.
    // ------------------------------------------------------------------

    task automatic compare_field(input string label, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        res_word_t nxt;
        res_word_t want;
        if (rst_n && evt_valid && !evt_stall)
        begin
            advance_backlight(evt, nxt);
            due_res_q.push_back(nxt);
        end
        if (rst_n && res_valid && !res_stall)
        begin
            if (due_res_q.size() == 0)
            begin
                $display("%0t: result word with nothing pending, expected none, actual %p",
                         $time, res);
                mismatch_cnt++;
            end
            else
            begin
                want = due_res_q.pop_front();
                compare_field("brightness", int'(want.brightness), int'(res.brightness));
                compare_field("light_state", int'(want.light_state), int'(res.light_state));
                compare_field("enabled", int'(want.enabled), int'(res.enabled));
            end
        end
    end

    // ------------------------------------------------------------------
    // Pacing.
    // ------------------------------------------------------------------

    // Gap length: mostly none or short, now and then a long one.
    function automatic int gap_len();
        int r;
        int n;
        r = $urandom_range(99);
        if (r < 55)
        begin
            n = 0;
        end
        else if (r < 88)
        begin
            n = $urandom_range(3, 1);
        end
        else if (r < 97)
        begin
            n = $urandom_range(12, 4);
        end
        else
        begin
            n = $urandom_range(60, 20);
        end
        return n;
    endfunction

    // Receiver: stalls the result channel in random bursts. When a long
    // hold is requested it keeps the stall up for the hold length in hold_len,
    // counted here, so the block backs up into its event channel.
    initial
    begin : receiver
        int n;
        forever
        begin
            if (hold_req)
            begin
                res_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                n = pace_on ? gap_len() : 0;
                if (n > 0)
                begin
                    res_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
            res_stall <= 1'b0;
            @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Event sender and configuration writes.
    // ------------------------------------------------------------------

    function automatic evt_word_t event_word(input logic [1:0] func, input logic pressed,
                                             input logic is_local, input logic en);
        evt_word_t w;
        w.func         = func;
        w.key_pressed  = pressed;
        w.key_is_local = is_local;
        w.enable_value = en;
        return w;
    endfunction

    // Offer one word after an optional gap and hold it until it is taken.
    // Valid stays high when no gap follows, so back-to-back words flow.
    task automatic send_word(input evt_word_t w);
        int gap;
        gap = pace_on ? gap_len() : 0;
        if (gap > 0)
        begin
            evt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt       <= w;
        evt_valid <= 1'b1;
        do @(posedge clk); while (evt_stall);
    endtask

    // Stop offering words and wait until every owed result has come back,
    // so that the two-stage pipeline is drained.
    task automatic settle();
        evt_valid <= 1'b0;
        @(posedge clk);
        while (due_res_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_MAX_BRIGHTNESS: cfg_max      = val[BRIGHT_W-1:0];
            REG_STEP_SIZE:      cfg_step     = val[STEP_W-1:0];
            REG_STEP_PERIOD:    cfg_interval = val[INTERVAL_W-1:0];
            default:            cfg_timeout  = val[TIMEOUT_W-1:0];
        endcase
    endtask

    task automatic write_config(input int mx, input int stp, input int iv, input int to);
        settle();
        write_reg(REG_MAX_BRIGHTNESS, mx);
        write_reg(REG_STEP_SIZE, stp);
        write_reg(REG_STEP_PERIOD, iv);
        write_reg(REG_IDLE_TIMEOUT_MS, to);
    endtask

    // Random event, weighted toward ticks so fades and idle timeouts run to
    // completion, with enough key, activity and enable traffic to restart them.
    function automatic evt_word_t random_event();
        evt_word_t w;
        int        r;
        w.key_pressed  = 1'($urandom_range(1));
        w.key_is_local = 1'($urandom_range(1));
        w.enable_value = 1'($urandom_range(1));
        r = $urandom_range(99);
        if (r < 58)
        begin
            w.func = FUNC_TICK;
        end
        else if (r < 74)
        begin
            w.func = FUNC_KEY;
            if ($urandom_range(1))
            begin
                w.key_pressed  = 1'b1;
                w.key_is_local = 1'b1;
            end
        end
        else if (r < 86)
        begin
            w.func = FUNC_ACTIVITY;
        end
        else
        begin
            w.func         = FUNC_SET_ENABLE;
            w.enable_value = ($urandom_range(99) < 70);
        end
        return w;
    endfunction

    // One random phase: a fresh configuration, an enable to get the light
    // going, then random events.
    task automatic run_phase(input int n_items, input int mx, input int stp,
                             input int iv, input int to);
        write_config(mx, stp, iv, to);
        send_word(event_word(FUNC_SET_ENABLE, 1'($urandom_range(1)), 1'($urandom_range(1)),
                             1'b1));
        repeat (n_items - 1) send_word(random_event());
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Reset configuration first, then a short interval and zero timers so
    // that a full fade up, idle expiry and a rewake fit in a few words.
    // Ignored events (disabled activity, key releases, remote keys) are
    // mixed in along the way.
    task automatic test_wake_and_fade();
        send_word(event_word(FUNC_SET_ENABLE, 1'b0, 1'b0, 1'b1));
        send_word(event_word(FUNC_TICK, 1'b1, 1'b1, 1'b1));
        send_word(event_word(FUNC_SET_ENABLE, 1'b1, 1'b1, 1'b0));
        write_config(5, 2, 0, 0);
        send_word(event_word(FUNC_KEY, 1'b1, 1'b1, 1'b0));
        send_word(event_word(FUNC_ACTIVITY, 1'b0, 1'b0, 1'b0));
        send_word(event_word(FUNC_SET_ENABLE, 1'b0, 1'b0, 1'b1));
        send_word(event_word(FUNC_TICK, 1'b0, 1'b0, 1'b0));
        send_word(event_word(FUNC_TICK, 1'b0, 1'b0, 1'b0));
        send_word(event_word(FUNC_TICK, 1'b0, 1'b0, 1'b0));
        send_word(event_word(FUNC_TICK, 1'b0, 1'b0, 1'b0));
        send_word(event_word(FUNC_KEY, 1'b0, 1'b1, 1'b0));
        send_word(event_word(FUNC_KEY, 1'b1, 1'b0, 1'b0));
        send_word(event_word(FUNC_KEY, 1'b1, 1'b1, 1'b0));
        send_word(event_word(FUNC_TICK, 1'b0, 1'b0, 1'b0));
        send_word(event_word(FUNC_TICK, 1'b0, 1'b0, 1'b0));
        send_word(event_word(FUNC_ACTIVITY, 1'b1, 1'b1, 1'b1));
        send_word(event_word(FUNC_TICK, 1'b0, 1'b0, 1'b0));
        send_word(event_word(FUNC_SET_ENABLE, 1'b1, 1'b1, 1'b0));
    endtask

    // Full brightness in one step, then the maximum is cut while the light
    // is on; the next fade step down must land on the new maximum.
    task automatic test_lowered_max();
        write_config(255, 255, 1, 3);
        send_word(event_word(FUNC_SET_ENABLE, 1'b0, 1'b0, 1'b1));
        send_word(event_word(FUNC_TICK, 1'b0, 1'b0, 1'b0));
        write_config(10, 1, 1, 3);
        send_word(event_word(FUNC_TICK, 1'b0, 1'b0, 1'b0));
        send_word(event_word(FUNC_TICK, 1'b0, 1'b0, 1'b0));
        send_word(event_word(FUNC_TICK, 1'b0, 1'b0, 1'b0));
        send_word(event_word(FUNC_TICK, 1'b0, 1'b0, 1'b0));
        send_word(event_word(FUNC_SET_ENABLE, 1'b0, 1'b0, 1'b0));
    endtask

    // Largest interval and timeout: the first step still comes on the next
    // tick, after which the fade timer sits at its full count.
    task automatic test_slow_timers();
        write_config(255, 1, 65535, 1048575);
        send_word(event_word(FUNC_SET_ENABLE, 1'b1, 1'b0, 1'b1));
        send_word(event_word(FUNC_TICK, 1'b0, 1'b0, 1'b0));
        send_word(event_word(FUNC_SET_ENABLE, 1'b0, 1'b1, 1'b0));
    endtask

    // Random traffic over several settings, the register extremes among
    // them, and one phase with no idling on either side.
    task automatic test_random_traffic();
        run_phase(130, 255, $urandom_range(24, 8), 1, $urandom_range(30, 10));
        run_phase(130, 1, 255, 2, 1);
        run_phase(130, $urandom_range(255, 1), $urandom_range(40, 1), 0, 0);
        pace_on = 1'b0;
        run_phase(130, $urandom_range(255, 1), $urandom_range(255, 1),
                  $urandom_range(5, 1), $urandom_range(40, 5));
        pace_on = 1'b1;
        run_phase(130, $urandom_range(255, 1), $urandom_range(255, 1),
                  $urandom_range(4, 1), $urandom_range(20, 1));
        run_phase(100, 0, $urandom_range(255, 1), $urandom_range(3, 1), $urandom_range(10, 1));
    endtask

    // The receiver holds off for a long stretch while words keep coming
    // back to back, so the pipeline fills and the event channel stalls.
    task automatic test_full_backpressure();
        write_config(30, 3, 1, 8);
        pace_on  = 1'b0;
        hold_len = 60;
        hold_req = 1'b1;
        repeat (50) send_word(random_event());
        pace_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        // Predictor starts from the reset state and default registers.
        cfg_max      = MAX_BRIGHTNESS_RST;
        cfg_step     = STEP_SIZE_RST;
        cfg_interval = STEP_PERIOD_RST;
        cfg_timeout  = IDLE_TIMEOUT_MS_RST;
        lamp_state   = LIGHT_CODE_OFF;
        lamp_level   = '0;
        lamp_enabled = 1'b0;
        fade_left    = '0;
        idle_left    = '0;
        idle_live    = 1'b0;

        rst_n     <= 1'b0;
        evt_valid <= 1'b0;
        evt       <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_wake_and_fade();
        test_lowered_max();
        test_slow_timers();
        test_random_traffic();
        test_full_backpressure();

        settle();
        repeat (6) @(posedge clk);
        if (mismatch_cnt == 0 && due_res_q.size() == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #(30_000_000);
        $display("tb NOT OK");
        $finish;
    end

endmodule
